>>> hw/rtl/klmt_pkg.sv
// ----------------------------------------------------------------------------
// klmt_pkg
// Shared types and codes of the keyed line mark table: request and result
// payloads, operation and status codes, configuration register map.
// ----------------------------------------------------------------------------
`default_nettype none

package klmt_pkg;

  localparam int KEY_W    = 8;
  localparam int LINE_W   = 32;
  localparam int COLUMN_W = 16;

  // operation codes
  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;
  localparam logic [1:0] OP_DELETE = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NOT_SET = 2'd1;
  localparam logic [1:0] STATUS_DELETED = 2'd2;

  // register map, index taken from paddr[2]
  localparam int         CFG_ADDR_W  = 3;
  localparam int         CFG_DATA_W  = 32;
  localparam logic       REG_PRIMARY = 1'b0;
  localparam logic       REG_ALIAS   = 1'b1;
  localparam logic [7:0] PRIMARY_RST = 8'd39;
  localparam logic [7:0] ALIAS_RST   = 8'd96;

  typedef struct packed {
    logic [1:0]          op;
    logic [KEY_W-1:0]    key;
    logic [LINE_W-1:0]   line_number;
    logic [COLUMN_W-1:0] set_column;
    logic                user_set;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [LINE_W-1:0]   mark_line;
    logic [COLUMN_W-1:0] mark_column;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] abs_key_primary;
    logic [KEY_W-1:0] abs_key_alias;
  } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/keyed_line_mark_table_top.sv
// ----------------------------------------------------------------------------
// keyed_line_mark_table_top
// Table of position marks indexed by key, kept in one synchronous RAM.
// ----------------------------------------------------------------------------
// usage:
//   in_*  : request channel (valid/ready), one klmt_pkg::req_t per request
//   out_* : result channel (valid/ready), one klmt_pkg::rsp_t per request
//   psel/penable/pwrite/paddr/pwdata : config writes, reg 0 at 0x0 (primary
//           absolute key), reg 1 at 0x4 (alias key), pready always high
//   set and get: one RAM read, then modify and write back; the result is
//           registered in the modify step, once the output register is free
//   line insert and delete: a read-modify-write sweep over all 2^KEY_BITS
//           entries, reads and writes overlapped one entry apart
//   one request is worked on at a time; the next is taken once the
//   current one has written back
//   reset: a clearing pass writes every entry to zero, with in_ready low;
//           config writes are taken throughout
//   a stalled result sits in the output register, and a new request can
//   be taken meanwhile; its own result waits until that register frees
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_line_mark_table_top #(
  parameter int KEY_BITS    = 8,
  parameter int LINE_BITS   = 32,
  parameter int COLUMN_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire klmt_pkg::req_t                  in_data,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output klmt_pkg::rsp_t                       out_data,
  // config port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [klmt_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [klmt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [klmt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import klmt_pkg::*;

  localparam int DEPTH    = 1 << KEY_BITS;
  localparam int CNT_BITS = KEY_BITS + 1;
  localparam int ENTRY_W  = 3 + LINE_BITS + COLUMN_BITS;

  // sequencer states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_OP    = 2'd2;
  localparam logic [1:0] ST_SWEEP = 2'd3;

  typedef struct packed {
    logic                   valid;
    logic                   user;
    logic                   deleted;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
  } entry_t;

  cfg_t cfg;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  req_t                req_r;
  logic [KEY_BITS-1:0] key_r;
  logic                out_valid_r;
  rsp_t                out_data_r;

  logic                in_acc;
  logic [KEY_W-1:0]    key_map;
  logic [KEY_BITS-1:0] key_res;
  logic                slot_free;
  logic                out_load;
  rsp_t                rsp_nxt;

  logic                rd_en;
  logic [KEY_BITS-1:0] rd_addr;
  logic                wr_en;
  logic [KEY_BITS-1:0] wr_addr;
  entry_t              wr_data;
  entry_t              rd_entry;
  logic [ENTRY_W-1:0]  rd_word;

  logic [LINE_BITS-1:0]   req_line;
  logic [COLUMN_BITS-1:0] req_col;
  entry_t                 set_entry;
  entry_t                 sweep_entry;
  logic                   keep_mark;

  klmt_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  klmt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  assign rd_entry = rd_word;

  // alias key folds onto the primary absolute key, then masked to the table
  assign key_map = (in_data.key == cfg.abs_key_alias) ? cfg.abs_key_primary : in_data.key;
  assign key_res = KEY_BITS'(key_map);

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  assign req_line = LINE_BITS'(req_r.line_number);
  assign req_col  = COLUMN_BITS'(req_r.set_column);

  // undo restore must not clobber a live user mark
  assign keep_mark = rd_entry.valid && !req_r.user_set && !rd_entry.deleted && rd_entry.user;

  always_comb begin
    set_entry         = '0;
    set_entry.valid   = 1'b1;
    set_entry.user    = req_r.user_set;
    set_entry.deleted = 1'b0;
    set_entry.line    = req_line;
    set_entry.column  = req_col;
  end

  // per-entry update of a line insert or delete sweep
  always_comb begin
    sweep_entry = rd_entry;
    if (rd_entry.valid) begin
      if (req_r.op == OP_INSERT) begin
        // saturate at the top line
        if ((rd_entry.line >= req_line) && (rd_entry.line != '1)) begin
          sweep_entry.line = rd_entry.line + 1'b1;
        end
      end else begin
        if (rd_entry.line == req_line) begin
          sweep_entry.deleted = 1'b1;
        end else if (rd_entry.line > req_line) begin
          sweep_entry.line = rd_entry.line - 1'b1;
        end
      end
    end
  end

  // result of the request in flight
  always_comb begin
    rsp_nxt = '0;
    rsp_nxt.status = STATUS_OK;
    if ((state_r == ST_OP) && (req_r.op == OP_GET)) begin
      if (!rd_entry.valid) begin
        rsp_nxt.status = STATUS_NOT_SET;
      end else if (rd_entry.deleted) begin
        rsp_nxt.status = STATUS_DELETED;
      end else begin
        rsp_nxt.mark_line   = LINE_W'(rd_entry.line);
        rsp_nxt.mark_column = COLUMN_W'(rd_entry.column);
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rd_en     = 1'b0;
    rd_addr   = key_res;
    wr_en     = 1'b0;
    wr_addr   = key_r;
    wr_data   = set_entry;
    out_load  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        // zero one entry per cycle after reset
        wr_en   = 1'b1;
        wr_addr = cnt_r[KEY_BITS-1:0];
        wr_data = '0;
        if (cnt_r[KEY_BITS-1:0] == '1) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = CNT_BITS'(cnt_r + 1'b1);
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if ((in_data.op == OP_SET) || (in_data.op == OP_GET)) begin
            rd_en     = 1'b1;
            state_nxt = ST_OP;
          end else begin
            cnt_nxt   = '0;
            state_nxt = ST_SWEEP;
          end
        end
      end
      ST_OP: begin
        // read data is held by the RAM while waiting for the result slot
        if (slot_free) begin
          out_load  = 1'b1;
          wr_en     = (req_r.op == OP_SET) && !keep_mark;
          state_nxt = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        // read entry cnt while writing back entry cnt-1
        rd_en   = !cnt_r[KEY_BITS];
        rd_addr = cnt_r[KEY_BITS-1:0];
        wr_en   = (cnt_r != '0);
        wr_addr = KEY_BITS'(cnt_r[KEY_BITS-1:0] - 1'b1);
        wr_data = sweep_entry;
        if (cnt_r[KEY_BITS]) begin
          // last write-back repeats harmlessly while the result stalls
          if (slot_free) begin
            out_load  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          cnt_nxt = CNT_BITS'(cnt_r + 1'b1);
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_data;
      key_r <= key_res;
    end
    if (out_load) begin
      out_data_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // read and write never hit the same entry in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("same entry read and written in one cycle");

  // a result never overwrites one still waiting
  a_no_result_loss: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // no request taken during the clearing pass
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("request taken while clearing");

  // set and get go to the modify step right after acceptance
  a_op_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && ((in_data.op == OP_SET) || (in_data.op == OP_GET))) |=> (state_r == ST_OP))
    else $error("set or get did not enter modify step");

  // a sweep ends only after its last write-back
  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SWEEP) && (state_nxt == ST_IDLE)) |-> (cnt_r[KEY_BITS] && wr_en))
    else $error("sweep left early");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/klmt_ram.sv
// ----------------------------------------------------------------------------
// klmt_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered and held while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module klmt_ram #(
  parameter int WIDTH = 51,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/klmt_apb_regs.sv
// ----------------------------------------------------------------------------
// klmt_apb_regs
// APB-style configuration registers: the two absolute mark keys.
// ----------------------------------------------------------------------------
`default_nettype none

module klmt_apb_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [klmt_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [klmt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [klmt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  output klmt_pkg::cfg_t                       cfg
);
  import klmt_pkg::*;

  logic [KEY_W-1:0] primary_r;
  logic [KEY_W-1:0] alias_r;
  logic             wr_go;
  logic             reg_idx;

  assign pready  = 1'b1;
  assign wr_go   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primary_r <= PRIMARY_RST;
      alias_r   <= ALIAS_RST;
    end else if (wr_go) begin
      unique case (reg_idx)
        REG_PRIMARY: primary_r <= pwdata[KEY_W-1:0];
        REG_ALIAS:   alias_r   <= pwdata[KEY_W-1:0];
        default:     primary_r <= primary_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PRIMARY: prdata = CFG_DATA_W'(primary_r);
      REG_ALIAS:   prdata = CFG_DATA_W'(alias_r);
      default:     prdata = '0;
    endcase
  end

  assign cfg.abs_key_primary = primary_r;
  assign cfg.abs_key_alias   = alias_r;

endmodule

`default_nettype wire
